/* src/rwsd_pkg.sv */
// ----------------------------------------------------------------------------
// rwsd_pkg
// Shared types and fixed constants of the rolling window standard deviation
// block: field widths, register defaults and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rwsd_pkg;

   // Fixed widths of the item fields and of the window length register.
   localparam int DATA_W = 24;
   localparam int LEN_W  = 7;

   // Window length register lower limit and reset value.
   localparam int LEN_MIN   = 2;
   localparam int LEN_RESET = 20;

   // Quotient bits produced per cycle by the divider.
   localparam int DIV_BITS_PER_STEP = 4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // latch the input item, read the oldest window entry
      logic load;       // capture the oldest entry, square the new sample
      logic mult;       // square the sum, scale the sum of squares
      logic num_init;   // square the oldest entry, form the radicand, start root and mean division
      logic sqrt_step;  // one root iteration
      logic div_step;   // one divider step
      logic root_init;  // keep the mean, start dividing the root
      logic update;     // retire the item: sums, window, result register
   } rwsd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;       // a full window preceded the current item
   } rwsd_status_type;

endpackage

/* src/rolling_window_std_dev.sv */
// ----------------------------------------------------------------------------
// rolling_window_std_dev
// Population mean and standard deviation of the previous window of samples,
// reported once the window has filled, with a ring store of past samples.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   req_     in         tdata: sample; tlast: end of series
//   rsp_     out        tdata: window mean, std deviation; tuser: stats valid
//   csr_     in         wdata: window length (write enable, no read-back)
//
// A warm-up item goes from its take and load straight to retirement, where its
// result is registered. An item with a full window also runs the products, the
// one-bit-per-cycle square root over the radicand and the division of the root
// by the window length before it retires. The next item can be taken in the
// cycle after the previous one retires. A result waiting on rsp_ blocks only
// the retirement of the following item. Reset is synchronous; the window
// store is not cleared, since entries are read only after being written in a
// warm-up.
//
module rolling_window_std_dev #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rwsd_pkg::DATA_W-1:0]   req_tdata,   // [23:0] sample
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*rwsd_pkg::DATA_W-1:0] rsp_tdata,   // [23:0] window_mean, [47:24] std_dev
   output logic                          rsp_tuser,   // [0] stats_valid
   input  logic                          csr_we,
   input  logic [rwsd_pkg::LEN_W-1:0]    csr_wdata
);

   localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW_MAX);
   localparam int DSTEP     = rwsd_pkg::DIV_BITS_PER_STEP;
   localparam int DIV_STEPS = (SUM_W + DSTEP - 1) / DSTEP;

   rwsd_pkg::rwsd_cmd_type    cmd;
   rwsd_pkg::rwsd_status_type status;

   rwsd_ctrl #(
      .SQRT_STEPS (SUM_W),
      .DIV_STEPS  (DIV_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rwsd_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* src/rwsd_ram.sv */
// ----------------------------------------------------------------------------
// rwsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rwsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rwsd_datapath.sv */
// ----------------------------------------------------------------------------
// rwsd_datapath
// Window store, running sums, squaring multiplier, iterative square root,
// shared iterative divider and the result register.
// ----------------------------------------------------------------------------
module rwsd_datapath #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rwsd_pkg::rwsd_cmd_type       cmd,
   output rwsd_pkg::rwsd_status_type    status,
   input  logic [rwsd_pkg::DATA_W-1:0]  req_tdata,
   input  logic                         req_tlast,
   input  logic                         csr_we,
   input  logic [rwsd_pkg::LEN_W-1:0]   csr_wdata,
   output logic [2*rwsd_pkg::DATA_W-1:0] rsp_tdata,
   output logic                         rsp_tuser
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PW     = $clog2(WINDOW_MAX);
   localparam int SUM_W  = SB + PW;
   localparam int SQ_W   = 2 * SB + PW;
   localparam int NUM_W  = 2 * SUM_W;
   localparam int DSTEP  = rwsd_pkg::DIV_BITS_PER_STEP;
   localparam int DIV_W  = ((SUM_W + DSTEP - 1) / DSTEP) * DSTEP;
   localparam int LW     = rwsd_pkg::LEN_W;
   localparam int CMP_W  = (PW + 1 > LW) ? PW + 1 : LW;
   localparam int LEN_HI = (WINDOW_MAX > (2**LW) - 1) ? (2**LW) - 1 : WINDOW_MAX;
   localparam int LEN_RS = (rwsd_pkg::LEN_RESET > LEN_HI) ? LEN_HI : rwsd_pkg::LEN_RESET;

   localparam logic [LW-1:0] LEN_MAX_V   = LW'(LEN_HI);
   localparam logic [LW-1:0] LEN_MIN_V   = LW'(rwsd_pkg::LEN_MIN);
   localparam logic [LW-1:0] LEN_RESET_V = LW'(LEN_RS);

   // Window and running state.
   logic [LW-1:0]    len_ff;
   logic [LW-1:0]    fill_ff;
   logic [PW-1:0]    pos_ff;
   logic [SUM_W-1:0] s1_ff;
   logic [SQ_W-1:0]  s2_ff;

   // Current item.
   logic [SB-1:0]    samp_ff;
   logic             last_ff;
   logic             full_ff;
   logic [SB-1:0]    old_ff;
   logic [SB-1:0]    old_rd;

   // Products.
   logic [2*SB-1:0]  sqn_ff;
   logic [2*SB-1:0]  sqo_ff;
   logic [NUM_W-1:0] s1sq_ff;
   logic [NUM_W-1:0] ps2_ff;
   logic [SUM_W-1:0] mul_a;
   logic [SUM_W-1:0] mul_b;
   logic [NUM_W-1:0] mul_p;

   // Square root.
   logic [NUM_W-1:0] rad_ff, rad_in;
   logic [NUM_W-1:0] root_ff, root_in;
   logic [NUM_W-1:0] bit_ff;
   logic [NUM_W-1:0] root_trial;

   // Divider.
   logic [DIV_W-1:0] div_q_ff, div_q_in;
   logic [LW-1:0]    div_r_ff, div_r_in;
   logic [SB-1:0]    mean_q_ff;

   // Result register.
   logic                     res_valid_ff;
   logic [rwsd_pkg::DATA_W-1:0] res_mean_ff;
   logic [rwsd_pkg::DATA_W-1:0] res_std_ff;

   logic [LW-1:0]    len_in;
   logic [CMP_W-1:0] pos_inc;

   rwsd_ram #(
      .WIDTH (SB),
      .DEPTH (WINDOW_MAX)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (pos_ff),
      .wr_data (samp_ff),
      .rd_en   (cmd.take),
      .rd_addr (pos_ff),
      .rd_data (old_rd)
   );

   // Write data saturated into the supported window range.
   always_comb begin
      if (csr_wdata < LEN_MIN_V) begin
         len_in = LEN_MIN_V;
      end else if (csr_wdata > LEN_MAX_V) begin
         len_in = LEN_MAX_V;
      end else begin
         len_in = csr_wdata;
      end
   end

   // One squaring multiplier shared by the new sample, the oldest sample and the sum.
   always_comb begin
      if (cmd.mult) begin
         mul_a = s1_ff;
      end else if (cmd.num_init) begin
         mul_a = SUM_W'(old_ff);
      end else begin
         mul_a = SUM_W'(samp_ff);
      end
      mul_b = mul_a;
      mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);
   end

   // Digit-by-digit integer square root, one result bit per step.
   always_comb begin
      root_trial = root_ff + bit_ff;
      if (rad_ff >= root_trial) begin
         rad_in  = rad_ff - root_trial;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rad_in  = rad_ff;
         root_in = root_ff >> 1;
      end
   end

   // Restoring division by the window length, several quotient bits per step.
   always_comb begin
      logic [LW:0]      r_wide;
      logic [LW-1:0]    r_cur;
      logic [DIV_W-1:0] q_cur;
      r_cur = div_r_ff;
      q_cur = div_q_ff;
      for (int k = 0; k < DSTEP; k++) begin
         r_wide = {r_cur, q_cur[DIV_W-1]};
         q_cur  = q_cur << 1;
         if (r_wide >= {1'b0, len_ff}) begin
            r_wide   = r_wide - {1'b0, len_ff};
            q_cur[0] = 1'b1;
         end
         r_cur = r_wide[LW-1:0];
      end
      div_r_in = r_cur;
      div_q_in = q_cur;
   end

   assign pos_inc = CMP_W'(pos_ff) + CMP_W'(1);

   // Window length, fill count, write position and running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_RESET_V;
         fill_ff <= '0;
         pos_ff  <= '0;
         s1_ff   <= '0;
         s2_ff   <= '0;
      end else if (csr_we) begin
         len_ff  <= len_in;
         fill_ff <= '0;
         pos_ff  <= '0;
         s1_ff   <= '0;
         s2_ff   <= '0;
      end else if (cmd.update) begin
         if (last_ff) begin
            fill_ff <= '0;
            pos_ff  <= '0;
            s1_ff   <= '0;
            s2_ff   <= '0;
         end else begin
            if (pos_inc >= CMP_W'(len_ff)) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_inc[PW-1:0];
            end
            if (full_ff) begin
               s1_ff <= s1_ff - SUM_W'(old_ff) + SUM_W'(samp_ff);
               s2_ff <= s2_ff - SQ_W'(sqo_ff) + SQ_W'(sqn_ff);
            end else begin
               s1_ff   <= s1_ff + SUM_W'(samp_ff);
               s2_ff   <= s2_ff + SQ_W'(sqn_ff);
               fill_ff <= fill_ff + LW'(1);
            end
         end
      end
   end

   // Item registers, arithmetic units and result register.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         samp_ff <= req_tdata[SB-1:0];
         last_ff <= req_tlast;
         full_ff <= (fill_ff >= len_ff);
      end
      if (cmd.load) begin
         old_ff <= old_rd;
         sqn_ff <= mul_p[2*SB-1:0];
      end
      if (cmd.mult) begin
         s1sq_ff <= mul_p;
         ps2_ff  <= NUM_W'(len_ff) * NUM_W'(s2_ff);
      end
      if (cmd.num_init) begin
         sqo_ff   <= mul_p[2*SB-1:0];
         // The true difference is never negative, so it fits in the radicand width.
         rad_ff   <= ps2_ff - s1sq_ff;
         root_ff  <= '0;
         bit_ff   <= NUM_W'(1) << (NUM_W - 2);
         div_q_ff <= DIV_W'(s1_ff);
         div_r_ff <= '0;
      end else begin
         if (cmd.sqrt_step) begin
            rad_ff  <= rad_in;
            root_ff <= root_in;
            bit_ff  <= bit_ff >> 2;
         end
         if (cmd.root_init) begin
            mean_q_ff <= div_q_ff[SB-1:0];
            div_q_ff  <= DIV_W'(root_ff[SUM_W-1:0]);
            div_r_ff  <= '0;
         end else if (cmd.div_step) begin
            div_q_ff <= div_q_in;
            div_r_ff <= div_r_in;
         end
      end
      if (cmd.update) begin
         res_valid_ff <= full_ff;
         if (full_ff) begin
            res_mean_ff <= rwsd_pkg::DATA_W'(mean_q_ff);
            res_std_ff  <= rwsd_pkg::DATA_W'(div_q_ff[SB-1:0]);
         end else begin
            res_mean_ff <= '0;
            res_std_ff  <= '0;
         end
      end
   end

   assign status.full = full_ff;
   assign rsp_tdata   = {res_std_ff, res_mean_ff};
   assign rsp_tuser   = res_valid_ff;

endmodule

/* src/rwsd_ctrl.sv */
// ----------------------------------------------------------------------------
// rwsd_ctrl
// Sequencer for one item: sample load, products, root and division steps,
// and retirement into the result register.
// ----------------------------------------------------------------------------
module rwsd_ctrl #(
   parameter int SQRT_STEPS = 30,
   parameter int DIV_STEPS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output rwsd_pkg::rwsd_cmd_type    cmd,
   input  rwsd_pkg::rwsd_status_type status
);

   localparam int ITER_W = $clog2(SQRT_STEPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MULT,
      ST_NUM,
      ST_SQRT,
      ST_ROOT,
      ST_DIVR,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              ready_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              take;
   logic              slot_free;

   assign take      = req_tvalid && ready_ff;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = status.full ? ST_MULT : ST_FINISH;
         end
         ST_MULT: begin
            state_in = ST_NUM;
         end
         ST_NUM: begin
            state_in = ST_SQRT;
            iter_in  = ITER_W'(SQRT_STEPS);
         end
         ST_SQRT: begin
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            state_in = ST_DIVR;
            iter_in  = ITER_W'(DIV_STEPS);
         end
         ST_DIVR: begin
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.take      = (state_ff == ST_IDLE) && take;
      cmd.load      = (state_ff == ST_LOAD);
      cmd.mult      = (state_ff == ST_MULT);
      cmd.num_init  = (state_ff == ST_NUM);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      // The mean division runs in the first cycles of the root iterations.
      cmd.div_step  = ((state_ff == ST_SQRT) &&
                       (iter_ff > ITER_W'(SQRT_STEPS - DIV_STEPS))) ||
                      (state_ff == ST_DIVR);
      cmd.root_init = (state_ff == ST_ROOT);
      cmd.update    = (state_ff == ST_FINISH) && slot_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         ready_ff     <= (state_in == ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rolling window standard deviation block. A
// driver streams price samples from a queue, a predictor tracks the window,
// its running sums and warm-up, and a monitor compares every result transfer
// with the oldest prediction. Window length changes between phases.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W    = rwsd_pkg::DATA_W;
   localparam int LEN_W     = rwsd_pkg::LEN_W;
   localparam int LEN_MIN   = rwsd_pkg::LEN_MIN;
   localparam int LEN_RESET = rwsd_pkg::LEN_RESET;

   localparam int WIN_MAX = 64;
   localparam logic [DATA_W-1:0] SAMPLE_MAX = {DATA_W{1'b1}};

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic              last;
   } price_item_type;

   typedef struct packed {
      logic              stats_valid;
      logic [DATA_W-1:0] window_mean;
      logic [DATA_W-1:0] std_dev;
   } window_stats_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;    // [23:0] sample
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [2*DATA_W-1:0]   rsp_tdata;         // [23:0] window_mean, [47:24] std_dev
   logic                  rsp_tuser;         // [0] stats_valid
   logic                  csr_we = 1'b0;
   logic [LEN_W-1:0]      csr_wdata = '0;

   price_item_type   req_items[$];
   window_stats_type expected_stats[$];
   price_item_type   next_item;

   // Predictor state: ring of past samples and the sums over the window.
   logic [DATA_W-1:0] ring[WIN_MAX];
   logic [63:0]       acc_sum;
   logic [63:0]       acc_sqsum;
   int unsigned       ring_pos;
   int unsigned       warm_count;
   int unsigned       win_len;

   int   err_count = 0;
   int   results_seen = 0;
   int   send_gap = 0;
   int   rsp_gap = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   bit   no_idle = 1'b0;
   int   price = 24'h400000;

   rolling_window_std_dev #(
      .WINDOW_MAX(WIN_MAX),
      .SAMPLE_BITS(DATA_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      int          b;
      root = '0;
      for (b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n)
            root = trial;
      end
      return root;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Mostly a slow price walk, with extremes and arbitrary values mixed in.
   function automatic logic [DATA_W-1:0] random_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return SAMPLE_MAX;
      if (r < 4)
         return DATA_W'($urandom());
      price = price + int'($urandom_range(0, 4000)) - 2000;
      if (price < 0)
         price = 0;
      if (price > int'(SAMPLE_MAX))
         price = int'(SAMPLE_MAX);
      return DATA_W'(price);
   endfunction

   task automatic restart_series();
      acc_sum = '0;
      acc_sqsum = '0;
      ring_pos = 0;
      warm_count = 0;
   endtask

   task automatic predict_window_stats(input logic [DATA_W-1:0] smp, input logic last);
      window_stats_type res;
      logic [63:0]   wl;
      logic [63:0]   s64;
      logic [63:0]   old;
      logic [63:0]   radicand;
      int unsigned   pos;
      wl = 64'(win_len);
      s64 = 64'(smp);
      pos = ring_pos;
      if (pos >= win_len)
         pos = 0;
      if (warm_count >= win_len) begin
         old = 64'(ring[pos]);
         radicand = wl * acc_sqsum - acc_sum * acc_sum;
         res.stats_valid = 1'b1;
         res.window_mean = DATA_W'(acc_sum / wl);
         res.std_dev = DATA_W'(int_sqrt(radicand) / wl);
         acc_sum = acc_sum - old + s64;
         acc_sqsum = acc_sqsum - old * old + s64 * s64;
      end else begin
         res = '0;
         acc_sum = acc_sum + s64;
         acc_sqsum = acc_sqsum + s64 * s64;
         warm_count++;
      end
      ring[pos] = smp;
      pos++;
      if (pos >= win_len)
         pos = 0;
      ring_pos = pos;
      if (last)
         restart_series();
      expected_stats.push_back(res);
   endtask

   task automatic check_window_stats();
      window_stats_type exp_res;
      if (expected_stats.size() == 0) begin
         $error("result transfer with no expectation pending");
         err_count++;
         return;
      end
      exp_res = expected_stats.pop_front();
      if (rsp_tuser !== exp_res.stats_valid) begin
         $error("stats_valid: expected %0d, got %0d", exp_res.stats_valid, rsp_tuser);
         err_count++;
      end
      if (rsp_tdata[DATA_W-1:0] !== exp_res.window_mean) begin
         $error("window_mean: expected %0d, got %0d",
                exp_res.window_mean, rsp_tdata[DATA_W-1:0]);
         err_count++;
      end
      if (rsp_tdata[2*DATA_W-1:DATA_W] !== exp_res.std_dev) begin
         $error("std_dev: expected %0d, got %0d",
                exp_res.std_dev, rsp_tdata[2*DATA_W-1:DATA_W]);
         err_count++;
      end
   endtask

   // Driver: prediction is made on the transfer, with the values still driven.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_window_stats(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (req_items.size() > 0) begin
               next_item = req_items.pop_front();
               req_tdata <= next_item.sample;
               req_tlast <= next_item.last;
               req_tvalid <= 1'b1;
               if (!no_idle && $urandom_range(0, 3) == 0)
                  send_gap = idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: one long hold-off while items are still queued, so the block
   // backs up into its input, plus random short and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_window_stats();
            results_seen++;
         end
         if (!hold_done && results_seen >= 60 && req_items.size() > 8) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rsp_gap == 0 && !no_idle && $urandom_range(0, 5) == 0)
               rsp_gap = idle_len();
            if (rsp_gap > 0) begin
               rsp_gap--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   task automatic push_item(input logic [DATA_W-1:0] smp, input logic last);
      price_item_type it;
      it.sample = smp;
      it.last = last;
      req_items.push_back(it);
   endtask

   // Wait until every item has been taken and every result has come back.
   task automatic settle();
      while (req_items.size() != 0 || req_tvalid || expected_stats.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_window_length(input logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      if (value < LEN_MIN)
         win_len = LEN_MIN;
      else if (value > WIN_MAX)
         win_len = WIN_MAX;
      else
         win_len = value;
      restart_series();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int unsigned i;
      int unsigned n;
      int unsigned random_items;
      int unsigned phase;
      logic [LEN_W-1:0] len_value;

      for (i = 0; i < WIN_MAX; i++)
         ring[i] = '0;
      win_len = LEN_RESET;
      restart_series();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Window length as it comes out of reset.
      for (i = 0; i < 26; i++)
         push_item(random_sample(), 1'b0);
      random_items = 26;
      settle();

      // Zero saturates to the shortest window; extremes of the sample.
      write_window_length('0);
      push_item(SAMPLE_MAX, 1'b0);
      push_item(SAMPLE_MAX, 1'b0);
      push_item('0, 1'b0);
      push_item(SAMPLE_MAX, 1'b0);
      push_item('0, 1'b1);
      push_item(24'd1, 1'b0);
      push_item(24'd2, 1'b0);
      push_item(24'd3, 1'b0);
      settle();

      // One also saturates; a window of zeros, ending the series on a result.
      write_window_length(7'd1);
      push_item('0, 1'b0);
      push_item('0, 1'b0);
      push_item('0, 1'b1);
      push_item(24'h800000, 1'b0);
      settle();

      write_window_length(7'd3);
      push_item(SAMPLE_MAX, 1'b0);
      push_item('0, 1'b0);
      push_item(SAMPLE_MAX, 1'b0);
      push_item('0, 1'b0);
      push_item(24'h555555, 1'b0);
      push_item(24'hAAAAAA, 1'b0);
      settle();

      phase = 0;
      while (random_items < 500) begin
         case (phase)
            0: len_value = 7'd127;
            1: len_value = 7'd64;
            2: len_value = LEN_W'($urandom_range(65, 126));
            3: len_value = LEN_W'($urandom_range(2, 6));
            default: begin
               if ($urandom_range(0, 3) == 0)
                  len_value = LEN_W'($urandom_range(0, 127));
               else
                  len_value = LEN_W'($urandom_range(2, 24));
            end
         endcase
         write_window_length(len_value);
         no_idle = ($urandom_range(0, 3) == 0);
         n = win_len + $urandom_range(10, 50);
         for (i = 0; i < n; i++)
            push_item(random_sample(), $urandom_range(0, 59) == 0);
         random_items += n;
         settle();
         phase++;
      end

      settle();
      repeat (50) @(negedge clock);
      if (err_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
src/rwsd_pkg.sv
src/rwsd_ram.sv
src/rwsd_datapath.sv
src/rwsd_ctrl.sv
src/rolling_window_std_dev.sv
tb/tb.sv
